// File: hw/rtl/cpd_pkg.sv
// shared types and constants for the patch column post decoder
package cpd_pkg;

  // defaults for the top-level parameters
  localparam int MaxHeightDefault    = 2048;
  localparam int MaxWidthDefault     = 2048;
  localparam int RemapEntriesDefault = 256;

  // fixed field widths
  localparam int HeightW = 12;
  localparam int ColW    = 11;
  localparam int PosW    = 24;
  localparam int ByteW   = 8;
  localparam int AddrW   = 22;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  // marker bytes and gaps
  localparam logic [ByteW-1:0]   EndByte   = 8'hFF;
  localparam logic [PosW:0]      HeaderGap = 25'd3;
  localparam logic [HeightW-1:0] RowMax    = 12'hFFF;
  localparam logic [7:0]         SkipCount = 8'd3;

  // request function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RAW       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEEP_ZERO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LUMP_LEN  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOP,
    PH_LEN,
    PH_PADA,
    PH_DATA,
    PH_PADB,
    PH_SKIP,
    PH_RAW
  } phase_t;

  typedef struct packed {
    logic [HeightW-1:0] height;
    logic               raw;
    logic               keep_zero;
    logic [PosW-1:0]    lump_len;
  } cfg_t;

  // result descriptor held between parser and output stage
  typedef struct packed {
    logic               valid;
    logic               write;
    logic               done;
    logic               zero_idx;
    logic [HeightW-1:0] row;
    logic [ColW-1:0]    column;
  } mid_t;

endpackage

// File: hw/rtl/patch_column_post_decoder.sv
// top level of the patch column post decoder
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    func, column_index, column_offset,
//                                             table_index, data_byte
// out       output     out_valid / out_ready  write_valid, pixel_address,
//                                             pixel_value, column_done
// cfg       input      cfg_write              cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a result is registered first in the descriptor
// register with the table read, then after the address multiply in the result register
// rst is synchronous and clears the parser, the pipeline valids and the configuration registers;
// the remap table holds no reset value and must be loaded before use
// a stalled output backs up through the descriptor stage into in_ready
module patch_column_post_decoder #(
  parameter int MAX_HEIGHT    = cpd_pkg::MaxHeightDefault,
  parameter int MAX_WIDTH     = cpd_pkg::MaxWidthDefault,
  parameter int REMAP_ENTRIES = cpd_pkg::RemapEntriesDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          func,
  input  logic [cpd_pkg::ColW-1:0]            column_index,
  input  logic [cpd_pkg::PosW-1:0]            column_offset,
  input  logic [$clog2(REMAP_ENTRIES)-1:0]    table_index,
  input  logic [cpd_pkg::ByteW-1:0]           data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                write_valid,
  output logic [cpd_pkg::AddrW-1:0]           pixel_address,
  output logic [cpd_pkg::ByteW-1:0]           pixel_value,
  output logic                                column_done,
  input  logic                                cfg_write,
  input  logic [cpd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cpd_pkg::CfgW-1:0]            cfg_data
);

  cpd_pkg::cfg_t                cfg;
  cpd_pkg::mid_t                mid;
  logic [cpd_pkg::HeightW-1:0]  eff_height;
  logic [cpd_pkg::ByteW-1:0]    remap_data;
  logic                         mid_take;
  logic                         accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height    <= 12'd128;
      cfg.raw       <= 1'b0;
      cfg.keep_zero <= 1'b0;
      cfg.lump_len  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cpd_pkg::CFG_HEIGHT:    cfg.height    <= cfg_data[cpd_pkg::HeightW-1:0];
        cpd_pkg::CFG_RAW:       cfg.raw       <= cfg_data[0];
        cpd_pkg::CFG_KEEP_ZERO: cfg.keep_zero <= cfg_data[0];
        cpd_pkg::CFG_LUMP_LEN:  cfg.lump_len  <= cfg_data[cpd_pkg::PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  // height clamped to the buffer limit
  always_comb begin
    if ({1'b0, cfg.height} > (cpd_pkg::HeightW+1)'(MAX_HEIGHT)) begin
      eff_height = cpd_pkg::HeightW'(MAX_HEIGHT);
    end else begin
      eff_height = cfg.height;
    end
  end

  assign in_ready = !mid.valid || mid_take;
  assign accept   = in_valid && in_ready;

  cpd_remap #(
    .REMAP_ENTRIES(REMAP_ENTRIES)
  ) u_remap (
    .clk    (clk),
    .wr_en  (accept && func == cpd_pkg::FUNC_LOAD),
    .wr_addr(table_index),
    .wr_data(data_byte),
    .rd_en  (accept),
    .rd_addr(data_byte[$clog2(REMAP_ENTRIES)-1:0]),
    .rd_data(remap_data)
  );

  cpd_parser #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mid_take     (mid_take),
    .func         (func),
    .column_index (column_index),
    .column_offset(column_offset),
    .data_byte    (data_byte),
    .cfg          (cfg),
    .eff_height   (eff_height),
    .mid          (mid)
  );

  cpd_output u_output (
    .clk          (clk),
    .rst          (rst),
    .mid          (mid),
    .remap_data   (remap_data),
    .keep_zero    (cfg.keep_zero),
    .eff_height   (eff_height),
    .mid_take     (mid_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .pixel_address(pixel_address),
    .pixel_value  (pixel_value),
    .column_done  (column_done)
  );

endmodule

// File: hw/rtl/cpd_remap.sv
// colour remap table with registered read
module cpd_remap #(
  parameter int REMAP_ENTRIES = cpd_pkg::RemapEntriesDefault
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(REMAP_ENTRIES)-1:0] wr_addr,
  input  logic [cpd_pkg::ByteW-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(REMAP_ENTRIES)-1:0] rd_addr,
  output logic [cpd_pkg::ByteW-1:0] rd_data
);

  logic [cpd_pkg::ByteW-1:0] mem [REMAP_ENTRIES];

  // table load
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // lookup for the request being accepted
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/cpd_parser.sv
// post structure parser and result descriptor register
module cpd_parser #(
  parameter int MAX_WIDTH = cpd_pkg::MaxWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          mid_take,
  input  logic [1:0]                    func,
  input  logic [cpd_pkg::ColW-1:0]      column_index,
  input  logic [cpd_pkg::PosW-1:0]      column_offset,
  input  logic [cpd_pkg::ByteW-1:0]     data_byte,
  input  cpd_pkg::cfg_t                 cfg,
  input  logic [cpd_pkg::HeightW-1:0]   eff_height,
  output cpd_pkg::mid_t                 mid
);

  cpd_pkg::phase_t              phase, phase_next;
  logic                         top_neg, top_neg_next;
  logic [cpd_pkg::HeightW-1:0]  top, top_next;
  logic [7:0]                   bytes_left, bytes_left_next;
  logic [cpd_pkg::HeightW-1:0]  row, row_next;
  logic [cpd_pkg::PosW-1:0]     pos, pos_next;
  logic [cpd_pkg::ColW-1:0]     column, column_next;

  logic [cpd_pkg::PosW-1:0]     pos_inc;
  logic [cpd_pkg::HeightW:0]    top_sum;
  logic [cpd_pkg::HeightW-1:0]  row_inc;
  logic [7:0]                   left_dec;
  logic                         fits_inc;
  logic                         fits_offs;
  logic                         row_in;
  logic                         raw_last;
  logic                         col_ok;
  cpd_pkg::mid_t                res;

  always_comb begin
    pos_inc   = pos + 1'b1;
    fits_inc  = ({1'b0, pos_inc} + cpd_pkg::HeaderGap) < {1'b0, cfg.lump_len};
    fits_offs = ({1'b0, column_offset} + cpd_pkg::HeaderGap) < {1'b0, cfg.lump_len};
    top_sum   = {1'b0, top} + {{(cpd_pkg::HeightW-cpd_pkg::ByteW+1){1'b0}}, data_byte};
    row_inc   = (row < cpd_pkg::RowMax) ? row + 1'b1 : row;
    left_dec  = (bytes_left != 8'd0) ? bytes_left - 1'b1 : bytes_left;
    row_in    = row < eff_height;
    raw_last  = ({1'b0, row} + 1'b1) >= {1'b0, eff_height};
    col_ok    = {2'b00, column_index} < (cpd_pkg::ColW+2)'(MAX_WIDTH);
  end

  // phase machine and result selection
  always_comb begin
    phase_next      = phase;
    top_neg_next    = top_neg;
    top_next        = top;
    bytes_left_next = bytes_left;
    row_next        = row;
    pos_next        = pos;
    column_next     = column;
    res             = '0;
    res.row         = row;
    res.column      = column;
    res.zero_idx    = data_byte == '0;

    case (func)
      cpd_pkg::FUNC_START: begin
        if (col_ok) begin
          column_next  = column_index;
          pos_next     = column_offset;
          top_neg_next = 1'b1;
          row_next     = '0;
          if (cfg.raw) begin
            bytes_left_next = cpd_pkg::SkipCount;
            phase_next      = cpd_pkg::PH_SKIP;
          end else begin
            bytes_left_next = '0;
            if (!fits_offs) begin
              phase_next = cpd_pkg::PH_IDLE;
              res.valid  = 1'b1;
              res.done   = 1'b1;
            end else begin
              phase_next = cpd_pkg::PH_TOP;
            end
          end
        end
      end
      cpd_pkg::FUNC_BYTE: begin
        if (phase != cpd_pkg::PH_IDLE) begin
          pos_next = pos_inc;
        end
        case (phase)
          cpd_pkg::PH_IDLE: begin
          end
          cpd_pkg::PH_TOP: begin
            if (data_byte == cpd_pkg::EndByte) begin
              phase_next = cpd_pkg::PH_IDLE;
              res.valid  = 1'b1;
              res.done   = 1'b1;
            end else begin
              // tall-patch rule: a top not above the current one is relative
              if (!top_neg &&
                  {{(cpd_pkg::HeightW-cpd_pkg::ByteW){1'b0}}, data_byte} <= top) begin
                top_next = top_sum[cpd_pkg::HeightW] ? cpd_pkg::RowMax :
                           top_sum[cpd_pkg::HeightW-1:0];
              end else begin
                top_next = {{(cpd_pkg::HeightW-cpd_pkg::ByteW){1'b0}}, data_byte};
              end
              top_neg_next = 1'b0;
              phase_next   = cpd_pkg::PH_LEN;
            end
          end
          cpd_pkg::PH_LEN: begin
            bytes_left_next = data_byte;
            row_next        = top_neg ? '0 : top;
            phase_next      = cpd_pkg::PH_PADA;
          end
          cpd_pkg::PH_PADA: begin
            phase_next = (bytes_left == 8'd0) ? cpd_pkg::PH_PADB : cpd_pkg::PH_DATA;
          end
          cpd_pkg::PH_DATA: begin
            res.valid       = row_in;
            res.write       = row_in;
            row_next        = row_inc;
            bytes_left_next = left_dec;
            if (left_dec == 8'd0) begin
              phase_next = cpd_pkg::PH_PADB;
            end
          end
          cpd_pkg::PH_PADB: begin
            if (!fits_inc) begin
              phase_next = cpd_pkg::PH_IDLE;
              res.valid  = 1'b1;
              res.done   = 1'b1;
            end else begin
              phase_next = cpd_pkg::PH_TOP;
            end
          end
          cpd_pkg::PH_SKIP: begin
            bytes_left_next = left_dec;
            if (left_dec == 8'd0) begin
              row_next = '0;
              if (eff_height == '0) begin
                phase_next = cpd_pkg::PH_IDLE;
                res.valid  = 1'b1;
                res.done   = 1'b1;
              end else begin
                phase_next = cpd_pkg::PH_RAW;
              end
            end
          end
          cpd_pkg::PH_RAW: begin
            res.valid = row_in || raw_last;
            res.write = row_in;
            res.done  = raw_last;
            row_next  = row_inc;
            if (raw_last) begin
              phase_next = cpd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_next = cpd_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cpd_pkg::PH_IDLE;
      top_neg    <= 1'b1;
      top        <= '0;
      bytes_left <= '0;
      row        <= '0;
      pos        <= '0;
      column     <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      top_neg    <= top_neg_next;
      top        <= top_next;
      bytes_left <= bytes_left_next;
      row        <= row_next;
      pos        <= pos_next;
      column     <= column_next;
    end
  end

  // result descriptor register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (accept) begin
      mid.write    <= res.write;
      mid.done     <= res.done;
      mid.zero_idx <= res.zero_idx;
      mid.row      <= res.row;
      mid.column   <= res.column;
    end
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (accept) begin
      mid.valid <= res.valid;
    end else if (mid_take) begin
      mid.valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/cpd_output.sv
// pixel address computation and result register
module cpd_output (
  input  logic                         clk,
  input  logic                         rst,
  input  cpd_pkg::mid_t                mid,
  input  logic [cpd_pkg::ByteW-1:0]    remap_data,
  input  logic                         keep_zero,
  input  logic [cpd_pkg::HeightW-1:0]  eff_height,
  output logic                         mid_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         write_valid,
  output logic [cpd_pkg::AddrW-1:0]    pixel_address,
  output logic [cpd_pkg::ByteW-1:0]    pixel_value,
  output logic                         column_done
);

  localparam int ProdW = cpd_pkg::ColW + cpd_pkg::HeightW;

  logic [ProdW-1:0]          prod;
  logic [ProdW-1:0]          addr_full;
  logic [cpd_pkg::ByteW-1:0] value;

  assign mid_take = mid.valid && (!out_valid || out_ready);

  // column times height plus row, and the remapped colour (zero for index zero when keep_zero is set)
  always_comb begin
    prod      = ProdW'(mid.column) * ProdW'(eff_height);
    addr_full = prod + ProdW'(mid.row);
    value     = (keep_zero && mid.zero_idx) ? '0 : remap_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_take) begin
      write_valid   <= mid.write;
      pixel_address <= mid.write ? addr_full[cpd_pkg::AddrW-1:0] : '0;
      pixel_value   <= mid.write ? value : '0;
      column_done   <= mid.done;
    end
  end

endmodule
